/* hdl/jddm_pkg.sv */
`default_nettype none

package jddm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int DUTY_BITS   = 8;
  localparam int CFG_W       = (SAMPLE_BITS > DUTY_BITS) ? SAMPLE_BITS : DUTY_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int KIND_W      = 4;

  // Datapath widths of the range map: operands, product, divider, result
  localparam int OPD_W  = SAMPLE_BITS + 2;
  localparam int DC_W   = DUTY_BITS + 1;
  localparam int PROD_W = OPD_W + DC_W;
  localparam int MAG_W  = PROD_W;
  localparam int DEN_W  = OPD_W;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int RES_W  = MAG_W + 2;
  localparam int MIX_W  = RES_W + 1;

  localparam logic signed [OPD_W-1:0] OPD_ONE = OPD_W'(1);

  localparam logic [SAMPLE_BITS-1:0] FWD_TH_RST   = SAMPLE_BITS'(501);
  localparam logic [SAMPLE_BITS-1:0] BWD_TH_RST   = SAMPLE_BITS'(521);
  localparam logic [SAMPLE_BITS-1:0] LEFT_TH_RST  = SAMPLE_BITS'(521);
  localparam logic [SAMPLE_BITS-1:0] RIGHT_TH_RST = SAMPLE_BITS'(501);
  localparam logic [SAMPLE_BITS-1:0] IN_MAX_RST   = SAMPLE_BITS'(1023);
  localparam logic [DUTY_BITS-1:0]   PWM_MAX_RST  = DUTY_BITS'(240);
  localparam logic [DUTY_BITS-1:0]   PWM_MIN_RST  = DUTY_BITS'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_TH,
    REG_BWD_TH,
    REG_LEFT_TH,
    REG_RIGHT_TH,
    REG_IN_MAX,
    REG_PWM_MAX,
    REG_PWM_MIN
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STOP,
    KIND_FWD,
    KIND_FWD_LEFT,
    KIND_FWD_RIGHT,
    KIND_BACK,
    KIND_BACK_LEFT,
    KIND_BACK_RIGHT,
    KIND_SPIN_LEFT,
    KIND_SPIN_RIGHT
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIN,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef enum logic {
    PASS_THR,
    PASS_TURN
  } pass_t;

endpackage

`default_nettype wire

/* hdl/jddm_if.sv */
`default_nettype none

interface jddm_in_if;
  logic                             valid;
  logic                             ready;
  logic [jddm_pkg::SAMPLE_BITS-1:0] throttle_axis;
  logic [jddm_pkg::SAMPLE_BITS-1:0] turn_axis;

  modport source (output valid, output throttle_axis, output turn_axis, input ready);
  modport sink   (input valid, input throttle_axis, input turn_axis, output ready);
endinterface

interface jddm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            left_direction;
  logic                            right_direction;
  logic [jddm_pkg::DUTY_BITS-1:0]  left_duty;
  logic [jddm_pkg::DUTY_BITS-1:0]  right_duty;
  logic [jddm_pkg::KIND_W-1:0]     motion_kind;

  modport source (output valid, output left_direction, output right_direction,
                  output left_duty, output right_duty, output motion_kind, input ready);
  modport sink   (input valid, input left_direction, input right_direction,
                  input left_duty, input right_duty, input motion_kind, output ready);
endinterface

`default_nettype wire

/* hdl/joystick_differential_drive_mixer.sv */
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    throttle_axis, turn_axis
// out_ch    out  valid/ready    left/right_direction, left/right_duty, motion_kind
// cfg_*     in   cfg_we only    cfg_index selects register, cfg_wdata
//
// A centred stick that owes nothing returns to idle from ST_DECIDE; the stop
// result goes straight to ST_DONE; a drive or a spin uses one range map, drive
// plus turn two. A map is a multiply state and a MAG_W (21) step restoring divide,
// skipped for a zero-width input range; the divider serves both maps in turn.
// in_ch.ready is high only in idle, so the next transaction is taken while the
// last result waits; a new result then holds in ST_DONE until out_ch drains.

module joystick_differential_drive_mixer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  jddm_in_if.sink                             in_ch,
  jddm_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jddm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SW    = jddm_pkg::SAMPLE_BITS;
  localparam int DW    = jddm_pkg::DUTY_BITS;
  localparam int OPD_W = jddm_pkg::OPD_W;
  localparam int DC_W  = jddm_pkg::DC_W;
  localparam int PROD_W = jddm_pkg::PROD_W;
  localparam int MAG_W = jddm_pkg::MAG_W;
  localparam int DEN_W = jddm_pkg::DEN_W;
  localparam int CNT_W = jddm_pkg::CNT_W;
  localparam int RES_W = jddm_pkg::RES_W;
  localparam int MIX_W = jddm_pkg::MIX_W;

  // clamp a mixed value into the duty range
  function automatic logic [DW-1:0] sat_duty(input logic signed [MIX_W-1:0] v);
    logic [DW-1:0] r;
    if (v[MIX_W-1]) begin
      r = '0;
    end else if (v[MIX_W-2:DW] != '0) begin
      r = '1;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [SW-1:0] fwd_th_r, bwd_th_r, left_th_r, right_th_r, in_max_r;
  logic [DW-1:0] pwm_max_r, pwm_min_r;

  // control state
  jddm_pkg::state_t state_r, state_nxt;
  jddm_pkg::pass_t  pass_r, pass_nxt;
  logic             stopped_r, stopped_nxt;
  logic             held_ldir_r, held_ldir_nxt;
  logic             held_rdir_r, held_rdir_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // working registers
  logic [SW-1:0]              t_r, t_nxt, y_r, y_nxt;
  logic                       fw_r, fw_nxt, drive_r, drive_nxt;
  logic                       left_r, left_nxt, turn_r, turn_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [OPD_W-1:0]    den_r, den_nxt;
  logic [DW-1:0]              c_r, c_nxt;
  logic [MAG_W-1:0]           quo_r, quo_nxt;
  logic [DEN_W-1:0]           rem_r, rem_nxt;
  logic [DEN_W-1:0]           div_r, div_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [RES_W-1:0]    res_a_r, res_a_nxt, res_t_r, res_t_nxt;
  logic                       p_ldir_r, p_ldir_nxt, p_rdir_r, p_rdir_nxt;
  logic [DW-1:0]              p_lduty_r, p_lduty_nxt, p_rduty_r, p_rduty_nxt;
  jddm_pkg::kind_t            p_kind_r, p_kind_nxt;
  logic                       o_ldir_r, o_ldir_nxt, o_rdir_r, o_rdir_nxt;
  logic [DW-1:0]              o_lduty_r, o_lduty_nxt, o_rduty_r, o_rduty_nxt;
  jddm_pkg::kind_t            o_kind_r, o_kind_nxt;

  // combinational scratch
  logic signed [OPD_W-1:0]  x_s, a_s, b_s, diff_s;
  logic signed [DC_W-1:0]   c_s, d_s, dc_s;
  logic [DW-1:0]            c_u;
  logic [DEN_W:0]           rem_sh;
  logic                     rem_ge;
  logic signed [MAG_W:0]    q_s;
  logic signed [RES_W-1:0]  map_res;
  logic signed [MIX_W-1:0]  ld_s, rd_s, diff_mix;
  logic                     go_left, go_right, is_fw, is_bw;

  assign in_ch.ready            = (state_r == jddm_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.left_direction  = o_ldir_r;
  assign out_ch.right_direction = o_rdir_r;
  assign out_ch.left_duty       = o_lduty_r;
  assign out_ch.right_duty      = o_rduty_r;
  assign out_ch.motion_kind     = o_kind_r;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    stopped_nxt   = stopped_r;
    held_ldir_nxt = held_ldir_r;
    held_rdir_nxt = held_rdir_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    y_nxt         = y_r;
    fw_nxt        = fw_r;
    drive_nxt     = drive_r;
    left_nxt      = left_r;
    turn_nxt      = turn_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    c_nxt         = c_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    neg_nxt       = neg_r;
    res_a_nxt     = res_a_r;
    res_t_nxt     = res_t_r;
    p_ldir_nxt    = p_ldir_r;
    p_rdir_nxt    = p_rdir_r;
    p_lduty_nxt   = p_lduty_r;
    p_rduty_nxt   = p_rduty_r;
    p_kind_nxt    = p_kind_r;
    o_ldir_nxt    = o_ldir_r;
    o_rdir_nxt    = o_rdir_r;
    o_lduty_nxt   = o_lduty_r;
    o_rduty_nxt   = o_rduty_r;
    o_kind_nxt    = o_kind_r;

    // deadband decisions on the saturated samples
    go_left  = (y_r > left_th_r);
    go_right = !go_left && (y_r < right_th_r);
    is_fw    = (t_r < fwd_th_r);
    is_bw    = !is_fw && (t_r > bwd_th_r);

    // operand select for the range map (x - a) * (d - c) / (b - a) + c
    if (pass_r == jddm_pkg::PASS_THR) begin
      x_s = $signed(OPD_W'(t_r));
      if (fw_r) begin
        a_s = '0;
        b_s = $signed(OPD_W'(fwd_th_r)) - jddm_pkg::OPD_ONE;
        c_u = pwm_max_r;
        d_s = $signed(DC_W'(pwm_min_r));
      end else begin
        a_s = $signed(OPD_W'(bwd_th_r)) + jddm_pkg::OPD_ONE;
        b_s = $signed(OPD_W'(in_max_r));
        c_u = pwm_min_r;
        d_s = $signed(DC_W'(pwm_max_r));
      end
    end else begin
      x_s = $signed(OPD_W'(y_r));
      if (left_r) begin
        a_s = $signed(OPD_W'(left_th_r)) + jddm_pkg::OPD_ONE;
        b_s = $signed(OPD_W'(in_max_r));
        c_u = pwm_min_r;
        d_s = $signed(DC_W'(pwm_max_r));
      end else begin
        a_s = '0;
        b_s = $signed(OPD_W'(right_th_r)) - jddm_pkg::OPD_ONE;
        c_u = pwm_max_r;
        d_s = $signed(DC_W'(pwm_min_r));
      end
    end
    c_s    = $signed(DC_W'(c_u));
    diff_s = x_s - a_s;
    dc_s   = d_s - c_s;

    // one restoring divider step
    rem_sh = {rem_r, quo_r[MAG_W-1]};
    rem_ge = (rem_sh >= {1'b0, div_r});

    // signed quotient plus offset
    q_s     = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    map_res = RES_W'(q_s) + RES_W'($signed({1'b0, c_r}));

    diff_mix = MIX_W'(res_a_r) - MIX_W'(res_t_r);
    ld_s     = MIX_W'(res_a_r);
    rd_s     = MIX_W'(res_a_r);

    case (state_r)
      jddm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          t_nxt     = (in_ch.throttle_axis > in_max_r) ? in_max_r : in_ch.throttle_axis;
          y_nxt     = (in_ch.turn_axis > in_max_r) ? in_max_r : in_ch.turn_axis;
          state_nxt = jddm_pkg::ST_DECIDE;
        end
      end
      jddm_pkg::ST_DECIDE: begin
        fw_nxt    = is_fw;
        drive_nxt = is_fw || is_bw;
        left_nxt  = go_left;
        turn_nxt  = go_left || go_right;
        if (!(is_fw || is_bw) && !(go_left || go_right)) begin
          if (stopped_r) begin
            state_nxt = jddm_pkg::ST_IDLE;
          end else begin
            // one stop result, directions held
            stopped_nxt = 1'b1;
            p_ldir_nxt  = held_ldir_r;
            p_rdir_nxt  = held_rdir_r;
            p_lduty_nxt = '0;
            p_rduty_nxt = '0;
            p_kind_nxt  = jddm_pkg::KIND_STOP;
            state_nxt   = jddm_pkg::ST_DONE;
          end
        end else begin
          pass_nxt  = (is_fw || is_bw) ? jddm_pkg::PASS_THR : jddm_pkg::PASS_TURN;
          state_nxt = jddm_pkg::ST_MUL;
        end
      end
      jddm_pkg::ST_MUL: begin
        prod_nxt  = PROD_W'(diff_s) * PROD_W'(dc_s);
        den_nxt   = b_s - a_s;
        c_nxt     = c_u;
        state_nxt = jddm_pkg::ST_DIV_LOAD;
      end
      jddm_pkg::ST_DIV_LOAD: begin
        rem_nxt = '0;
        cnt_nxt = CNT_W'(MAG_W - 1);
        if (den_r == '0) begin
          // empty input range: the map gives its first output value
          quo_nxt   = '0;
          neg_nxt   = 1'b0;
          state_nxt = jddm_pkg::ST_FIN;
        end else begin
          quo_nxt   = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
          div_nxt   = den_r[OPD_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
          neg_nxt   = prod_r[PROD_W-1] ^ den_r[OPD_W-1];
          state_nxt = jddm_pkg::ST_DIV;
        end
      end
      jddm_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? DEN_W'(rem_sh - {1'b0, div_r}) : DEN_W'(rem_sh);
        quo_nxt = {quo_r[MAG_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = jddm_pkg::ST_FIN;
        end
      end
      jddm_pkg::ST_FIN: begin
        if (pass_r == jddm_pkg::PASS_THR) begin
          res_a_nxt = map_res;
          if (turn_r) begin
            pass_nxt  = jddm_pkg::PASS_TURN;
            state_nxt = jddm_pkg::ST_MUL;
          end else begin
            state_nxt = jddm_pkg::ST_MIX;
          end
        end else begin
          res_t_nxt = map_res;
          state_nxt = jddm_pkg::ST_MIX;
        end
      end
      jddm_pkg::ST_MIX: begin
        if (drive_r) begin
          if (turn_r && left_r) begin
            ld_s = diff_mix;
          end else if (turn_r) begin
            rd_s = diff_mix;
          end
          p_ldir_nxt = !fw_r;
          p_rdir_nxt = !fw_r;
          if (fw_r) begin
            p_kind_nxt = !turn_r ? jddm_pkg::KIND_FWD :
                         left_r  ? jddm_pkg::KIND_FWD_LEFT : jddm_pkg::KIND_FWD_RIGHT;
          end else begin
            p_kind_nxt = !turn_r ? jddm_pkg::KIND_BACK :
                         left_r  ? jddm_pkg::KIND_BACK_LEFT : jddm_pkg::KIND_BACK_RIGHT;
          end
        end else begin
          // spin on the spot
          ld_s       = MIX_W'(res_t_r);
          rd_s       = MIX_W'(res_t_r);
          p_ldir_nxt = left_r;
          p_rdir_nxt = !left_r;
          p_kind_nxt = left_r ? jddm_pkg::KIND_SPIN_LEFT : jddm_pkg::KIND_SPIN_RIGHT;
        end
        p_lduty_nxt   = sat_duty(ld_s);
        p_rduty_nxt   = sat_duty(rd_s);
        stopped_nxt   = 1'b0;
        held_ldir_nxt = p_ldir_nxt;
        held_rdir_nxt = p_rdir_nxt;
        state_nxt     = jddm_pkg::ST_DONE;
      end
      jddm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_ldir_nxt    = p_ldir_r;
          o_rdir_nxt    = p_rdir_r;
          o_lduty_nxt   = p_lduty_r;
          o_rduty_nxt   = p_rduty_r;
          o_kind_nxt    = p_kind_r;
          state_nxt     = jddm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jddm_pkg::ST_IDLE;
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jddm_pkg::ST_IDLE;
      pass_r      <= jddm_pkg::PASS_THR;
      stopped_r   <= 1'b1;
      held_ldir_r <= 1'b0;
      held_rdir_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      fwd_th_r    <= jddm_pkg::FWD_TH_RST;
      bwd_th_r    <= jddm_pkg::BWD_TH_RST;
      left_th_r   <= jddm_pkg::LEFT_TH_RST;
      right_th_r  <= jddm_pkg::RIGHT_TH_RST;
      in_max_r    <= jddm_pkg::IN_MAX_RST;
      pwm_max_r   <= jddm_pkg::PWM_MAX_RST;
      pwm_min_r   <= jddm_pkg::PWM_MIN_RST;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      stopped_r   <= stopped_nxt;
      held_ldir_r <= held_ldir_nxt;
      held_rdir_r <= held_rdir_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          jddm_pkg::REG_FWD_TH:   fwd_th_r   <= cfg_wdata[SW-1:0];
          jddm_pkg::REG_BWD_TH:   bwd_th_r   <= cfg_wdata[SW-1:0];
          jddm_pkg::REG_LEFT_TH:  left_th_r  <= cfg_wdata[SW-1:0];
          jddm_pkg::REG_RIGHT_TH: right_th_r <= cfg_wdata[SW-1:0];
          jddm_pkg::REG_IN_MAX:   in_max_r   <= cfg_wdata[SW-1:0];
          jddm_pkg::REG_PWM_MAX:  pwm_max_r  <= cfg_wdata[DW-1:0];
          jddm_pkg::REG_PWM_MIN:  pwm_min_r  <= cfg_wdata[DW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    y_r       <= y_nxt;
    fw_r      <= fw_nxt;
    drive_r   <= drive_nxt;
    left_r    <= left_nxt;
    turn_r    <= turn_nxt;
    prod_r    <= prod_nxt;
    den_r     <= den_nxt;
    c_r       <= c_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    neg_r     <= neg_nxt;
    res_a_r   <= res_a_nxt;
    res_t_r   <= res_t_nxt;
    p_ldir_r  <= p_ldir_nxt;
    p_rdir_r  <= p_rdir_nxt;
    p_lduty_r <= p_lduty_nxt;
    p_rduty_r <= p_rduty_nxt;
    p_kind_r  <= p_kind_nxt;
    o_ldir_r  <= o_ldir_nxt;
    o_rdir_r  <= o_rdir_nxt;
    o_lduty_r <= o_lduty_nxt;
    o_rduty_r <= o_rduty_nxt;
    o_kind_r  <= o_kind_nxt;
  end

endmodule

`default_nettype wire

/* sim/joystick_differential_drive_mixer_tb.sv */
`timescale 1ns / 100ps

module joystick_differential_drive_mixer_tb;

  localparam int SAMPLE_BITS   = jddm_pkg::SAMPLE_BITS;
  localparam int DUTY_BITS     = jddm_pkg::DUTY_BITS;
  localparam int CFG_W         = jddm_pkg::CFG_W;
  localparam int CFG_IDX_W     = jddm_pkg::CFG_IDX_W;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int IDLE_PCT      = 34;
  localparam int STALL_CYCLES  = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 80;      // covers the longest transaction, drive plus turn
  localparam int DRAIN_LIMIT   = 60000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
  localparam int DUTY_TOP      = (1 << DUTY_BITS) - 1;

  // No register lives at this index; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DUTY_BITS-1:0]   duty_t;

  typedef struct packed {
    sample_t throttle;
    sample_t turn;
  } stick_t;

  typedef struct packed {
    logic            ldir;
    logic            rdir;
    duty_t           lduty;
    duty_t           rduty;
    jddm_pkg::kind_t kind;
  } drive_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  jddm_in_if  in_ch ();
  jddm_out_if out_ch ();

  joystick_differential_drive_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the register file, kept in step with every write
  sample_t fwd_th   = jddm_pkg::FWD_TH_RST;
  sample_t bwd_th   = jddm_pkg::BWD_TH_RST;
  sample_t left_th  = jddm_pkg::LEFT_TH_RST;
  sample_t right_th = jddm_pkg::RIGHT_TH_RST;
  sample_t in_max   = jddm_pkg::IN_MAX_RST;
  duty_t   pwm_max  = jddm_pkg::PWM_MAX_RST;
  duty_t   pwm_min  = jddm_pkg::PWM_MIN_RST;

  // Mirror of the motor state: stopped flag and the directions held for a stop
  logic stopped   = 1'b1;
  logic held_ldir = 1'b0;
  logic held_rdir = 1'b0;

  stick_t stick_backlog [$];   // samples waiting to be offered
  drive_t mix_due [$];         // motor commands still owed by the block

  int  items_queued = 0;
  int  items_taken  = 0;
  int  faults       = 0;
  int  cycle_count  = 0;
  int  stall_left   = 0;
  bit  stall_done   = 1'b0;
  bit  stall_ask;              // request for the one long receiver hold-off
  bit  calm;                   // both sides run flat out while set
  bit  in_fired     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Linear range map, signed, division truncating toward zero.
  // A zero-width source range yields the first output value.
  function automatic longint scale_span(input longint x, input longint a, input longint b,
                                        input longint c, input longint d);
    longint span;
    span = b - a;
    if (span == 0) return c;
    return (x - a) * (d - c) / span + c;
  endfunction

  function automatic duty_t clip_duty(input longint v);
    if (v < 0) return '0;
    if (v > DUTY_TOP) return duty_t'(DUTY_TOP);
    return duty_t'(v);
  endfunction

  // Mixes one stick sample into a motor command. Returns 0 when the block owes
  // nothing (centred stick while already stopped). Updates the motor state.
  function automatic bit mix_stick(input stick_t s, output drive_t r);
    longint          t, y, imax, pmax, pmin, fwd, bwd, lth, rth, base, ld, rd;
    bit              go_left, go_right, forward;
    logic            ldir, rdir;
    jddm_pkg::kind_t kind;
    t = s.throttle;
    y = s.turn;
    imax = in_max;
    pmax = pwm_max;
    pmin = pwm_min;
    fwd = fwd_th;
    bwd = bwd_th;
    lth = left_th;
    rth = right_th;
    // samples beyond full deflection saturate first
    if (t > imax) t = imax;
    if (y > imax) y = imax;
    // left takes precedence when both turn thresholds overlap
    go_left  = y > lth;
    go_right = !go_left && y < rth;
    if (t < fwd || t > bwd) begin
      // forward takes precedence when the throttle thresholds overlap
      forward = t < fwd;
      if (forward) begin
        base = scale_span(t, 0, fwd - 1, pmax, pmin);
        ldir = 1'b0;
        rdir = 1'b0;
      end else begin
        base = scale_span(t, bwd + 1, imax, pmin, pmax);
        ldir = 1'b1;
        rdir = 1'b1;
      end
      ld = base;
      rd = base;
      // inner wheel slowed by the turn deflection; clipping gives the floor at 0
      if (go_left) begin
        ld = base - scale_span(y, lth + 1, imax, pmin, pmax);
        kind = forward ? jddm_pkg::KIND_FWD_LEFT : jddm_pkg::KIND_BACK_LEFT;
      end else if (go_right) begin
        rd = base - scale_span(y, 0, rth - 1, pmax, pmin);
        kind = forward ? jddm_pkg::KIND_FWD_RIGHT : jddm_pkg::KIND_BACK_RIGHT;
      end else begin
        kind = forward ? jddm_pkg::KIND_FWD : jddm_pkg::KIND_BACK;
      end
    end else if (go_left) begin
      ld = scale_span(y, lth + 1, imax, pmin, pmax);
      rd = ld;
      ldir = 1'b1;
      rdir = 1'b0;
      kind = jddm_pkg::KIND_SPIN_LEFT;
    end else if (go_right) begin
      ld = scale_span(y, 0, rth - 1, pmax, pmin);
      rd = ld;
      ldir = 1'b0;
      rdir = 1'b1;
      kind = jddm_pkg::KIND_SPIN_RIGHT;
    end else begin
      // both centred: one stop command, then silence until the stick moves
      if (stopped) return 1'b0;
      stopped = 1'b1;
      r = '{held_ldir, held_rdir, '0, '0, jddm_pkg::KIND_STOP};
      return 1'b1;
    end
    stopped = 1'b0;
    held_ldir = ldir;
    held_rdir = rdir;
    r = '{ldir, rdir, clip_duty(ld), clip_duty(rd), kind};
    return 1'b1;
  endfunction

  // One axis sample. lo_th/hi_th bound the deadband; centred forces a deadband
  // value, otherwise a mix of either side, the deadband, edges and raw noise.
  function automatic sample_t pick_axis(input sample_t lo_th, input sample_t hi_th,
                                        input bit centred);
    int unsigned lo, hi, roll;
    lo = lo_th;
    hi = hi_th;
    roll = centred ? 50 : $urandom_range(99);
    if (roll < 10) return sample_t'($urandom);
    if (roll < 22) begin
      case ($urandom_range(7))
        0:       return '0;
        1:       return sample_t'(SAMPLE_TOP);
        2:       return sample_t'(lo - 1);
        3:       return lo_th;
        4:       return hi_th;
        5:       return sample_t'(hi + 1);
        6:       return in_max;
        default: return sample_t'(in_max + 1);
      endcase
    end
    if (roll < 46) return sample_t'($urandom_range(lo == 0 ? 0 : lo - 1, 0));
    if (roll < 70) return sample_t'($urandom_range(hi, lo));
    return sample_t'($urandom_range(SAMPLE_TOP, hi >= SAMPLE_TOP ? SAMPLE_TOP : hi + 1));
  endfunction

  task automatic queue_stick(input int t, input int y);
    stick_backlog.push_back('{sample_t'(t), sample_t'(y)});
    items_queued++;
  endtask

  task automatic queue_random(input int n);
    stick_t s;
    bit     both;
    for (int k = 0; k < n; k++) begin
      // a share of fully centred sticks keeps the stop path busy
      both = ($urandom_range(99) < 12);
      s.throttle = pick_axis(fwd_th, bwd_th, both);
      s.turn = pick_axis(right_th, left_th, both);
      stick_backlog.push_back(s);
      items_queued++;
    end
  endtask

  // Register write, one per cycle; mirror follows at once since nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      jddm_pkg::REG_FWD_TH:   fwd_th = sample_t'(val);
      jddm_pkg::REG_BWD_TH:   bwd_th = sample_t'(val);
      jddm_pkg::REG_LEFT_TH:  left_th = sample_t'(val);
      jddm_pkg::REG_RIGHT_TH: right_th = sample_t'(val);
      jddm_pkg::REG_IN_MAX:   in_max = sample_t'(val);
      jddm_pkg::REG_PWM_MAX:  pwm_max = duty_t'(val);
      jddm_pkg::REG_PWM_MIN:  pwm_min = duty_t'(val);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds back until every transaction is taken and every command seen,
  // then lets a centred-stick transaction with no result run out as well
  task automatic settle();
    int waited;
    waited = 0;
    while ((items_taken != items_queued || mix_due.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Full register set, then a burst of random sticks under it.
  // Duty writes carry junk in the bits above the register width.
  task automatic run_phase(input int fwd, input int bwd, input int lth, input int rth,
                           input int imax, input int pmax, input int pmin, input int n);
    write_reg(jddm_pkg::REG_FWD_TH, CFG_W'(fwd));
    write_reg(jddm_pkg::REG_BWD_TH, CFG_W'(bwd));
    write_reg(jddm_pkg::REG_LEFT_TH, CFG_W'(lth));
    write_reg(jddm_pkg::REG_RIGHT_TH, CFG_W'(rth));
    write_reg(jddm_pkg::REG_IN_MAX, CFG_W'(imax));
    write_reg(jddm_pkg::REG_PWM_MAX,
              CFG_W'(pmax) | (CFG_W'($urandom_range(3)) << DUTY_BITS));
    write_reg(jddm_pkg::REG_PWM_MIN,
              CFG_W'(pmin) | (CFG_W'($urandom_range(3)) << DUTY_BITS));
    end_writes();
    @(posedge clk);
    queue_random(n);
    settle();
  endtask

  // Input side: offer the next sample at the falling edge, hold it until taken
  always @(negedge clk) begin
    stick_t nxt;
    bit     offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      offer = (stick_backlog.size() != 0) && (calm || $urandom_range(99) >= IDLE_PCT);
      if (offer) begin
        nxt = stick_backlog.pop_front();
        in_ch.throttle_axis <= nxt.throttle;
        in_ch.turn_axis <= nxt.turn;
      end
      in_ch.valid <= offer;
    end
  end

  // Input transaction seen at the rising edge: predict the command it owes
  always @(posedge clk) begin
    stick_t s;
    drive_t owed;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        s.throttle = in_ch.throttle_axis;
        s.turn = in_ch.turn_axis;
        if (mix_stick(s, owed)) mix_due.push_back(owed);
        items_taken <= items_taken + 1;
      end
    end
  end

  // The single long hold-off, counted here so the sender keeps pushing meanwhile
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_ask && !stall_done) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end
  end

  // Result side ready, random back-pressure at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Result transaction: compare field by field with the oldest command owed
  always @(posedge clk) begin
    drive_t owed, seen;
    string  bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.left_direction, out_ch.right_direction, out_ch.left_duty,
               out_ch.right_duty, jddm_pkg::kind_t'(out_ch.motion_kind)};
      bad = "";
      if (mix_due.size() == 0) begin
        owed = '0;
        bad = " unexpected transaction";
      end else begin
        owed = mix_due.pop_front();
        if (seen.ldir !== owed.ldir) bad = {bad, " left_direction"};
        if (seen.rdir !== owed.rdir) bad = {bad, " right_direction"};
        if (seen.lduty !== owed.lduty) bad = {bad, " left_duty"};
        if (seen.rduty !== owed.rduty) bad = {bad, " right_duty"};
        if (seen.kind !== owed.kind) bad = {bad, " motion_kind"};
      end
      if (bad != "") begin
        faults++;
        if (faults <= 10) begin
          $write("%0t mismatch:%s | owed dir %0b/%0b duty %0d/%0d kind %0d",
                 $realtime, bad, owed.ldir, owed.rdir, owed.lduty, owed.rduty, owed.kind);
          $display(" | seen dir %0b/%0b duty %0d/%0d kind %0d",
                   seen.ldir, seen.rdir, seen.lduty, seen.rduty, seen.kind);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("joystick_differential_drive_mixer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.throttle_axis = '0;
    in_ch.turn_axis = '0;
    out_ch.ready = 1'b0;
    stall_ask = 1'b0;
    calm = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // stray index: registers must keep their reset values
    write_reg(REG_NONE, '1);
    end_writes();
    @(posedge clk);

    // Directed sticks at reset settings (deadband 501..521 on both axes)
    queue_stick(510, 510);    // centred straight out of reset: nothing owed
    queue_stick(0, 510);      // full forward
    queue_stick(510, 510);    // stop, forward directions held
    queue_stick(510, 510);    // already stopped: silent
    queue_stick(1023, 510);   // full backward
    queue_stick(510, 510);    // stop, backward directions held
    queue_stick(0, 1023);     // forward left
    queue_stick(0, 0);        // forward right
    queue_stick(1023, 1023);  // backward left
    queue_stick(1023, 0);     // backward right
    queue_stick(510, 1023);   // spin left
    queue_stick(510, 0);      // spin right
    queue_stick(500, 510);    // just inside forward
    queue_stick(501, 501);    // deadband edges: stop
    queue_stick(521, 521);    // still centred: silent
    queue_stick(521, 522);    // spin left at the edge
    queue_stick(522, 500);    // backward right at the edges
    queue_stick(500, 1023);   // slow forward, hard left: inner wheel floors at zero
    queue_stick(522, 0);      // slow backward, hard right: floor on the right wheel
    queue_stick(256, 767);    // mid forward, mid left
    queue_stick(767, 256);    // mid backward, mid right
    queue_stick(520, 510);    // stop again
    settle();
    queue_random(110);
    settle();

    // low extremes: full deflection of 1, overlapping thresholds, zero duties
    run_phase(2, 1, 1, 2, 1, 0, 0, 120);
    // high extremes, held up by one long receiver stall at the start
    stall_ask = 1'b1;
    run_phase(1022, 1021, 1021, 1022, 1023, 255, 255, 120);
    // fully overlapping deadbands: forward and left take precedence
    run_phase(1022, 1, 1, 1022, 1023, 255, 0, 120);
    // zero-width map ranges on backward and left, samples saturating above 522
    run_phase(501, 521, 521, 501, 522, 255, 0, 120);
    // minimum duty above maximum, narrow full-deflection range
    run_phase(300, 700, 600, 400, 900, 17, 200, 120);
    // random settings; the first runs without any idling
    calm = 1'b1;
    run_phase($urandom_range(1022, 2), $urandom_range(1021, 1), $urandom_range(1021, 1),
              $urandom_range(1022, 2), $urandom_range(1023, 600), $urandom_range(255, 0),
              $urandom_range(255, 0), 120);
    calm = 1'b0;
    run_phase($urandom_range(1022, 2), $urandom_range(1021, 1), $urandom_range(1021, 1),
              $urandom_range(1022, 2), $urandom_range(1023, 1), $urandom_range(255, 0),
              $urandom_range(255, 0), 120);

    // samples never taken and commands never delivered count against the run
    faults = faults + mix_due.size() + (items_queued - items_taken);
    if (faults == 0)
      $display("joystick_differential_drive_mixer regression: pass");
    else
      $display("joystick_differential_drive_mixer regression: fail");
    $finish;
  end

endmodule

/* sim.f */
hdl/jddm_pkg.sv
hdl/jddm_if.sv
hdl/joystick_differential_drive_mixer.sv
sim/joystick_differential_drive_mixer_tb.sv
